### rtl/core/bms_pkg.sv
`default_nettype none

package bms_pkg;

  localparam int ITEM_W        = 8;
  localparam int MAX_ITEMS_DEF = 64;

  typedef struct packed {
    logic signed [ITEM_W-1:0] item;
    logic                     last_item;
  } bms_in_t;

  typedef struct packed {
    logic signed [ITEM_W-1:0] sorted_item;
    logic                     last_result;
    logic                     overflow;
  } bms_out_t;

endpackage

`default_nettype wire

### rtl/core/bms_ram.sv
`default_nettype none

module bms_ram #(
  parameter int DEPTH = bms_pkg::MAX_ITEMS_DEF,
  parameter int AW    = $clog2(bms_pkg::MAX_ITEMS_DEF)
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [bms_pkg::ITEM_W-1:0]  wdata,
  input  wire logic                        re_a,
  input  wire logic [AW-1:0]               raddr_a,
  input  wire logic                        re_b,
  input  wire logic [AW-1:0]               raddr_b,
  output logic      [bms_pkg::ITEM_W-1:0]  rd_a_r,
  output logic      [bms_pkg::ITEM_W-1:0]  rd_b_r
);

  logic [bms_pkg::ITEM_W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read data holds while the port is not enabled
  always_ff @(posedge clk) begin
    if (re_a) begin
      rd_a_r <= mem_r[raddr_a];
    end
    if (re_b) begin
      rd_b_r <= mem_r[raddr_b];
    end
  end

endmodule

`default_nettype wire

### rtl/core/byte_merge_sorter.sv
// byte_merge_sorter: stable ascending sort of a batch of signed bytes.
// Input channel in_*: one byte per beat, in_data.last_item closes the batch.
// Up to MAX_ITEMS bytes are stored; further bytes of the batch are dropped
// and every result of that batch carries overflow.
// Result channel out_*: the batch in ascending signed order, one byte per
// beat, out_data.last_result on the final one.
// While loading, every offered beat is taken. After the closing beat the
// block runs bottom-up merge passes between two ping-pong RAMs (two read
// ports, one write port each): each run pair of a pass gets a setup step,
// then its two runs are merged into the other RAM; there are ceil(log2 n)
// passes. Emission then reads the final RAM one result at a time: a read
// state (EMIT_RD), then a load of the output register (EMIT_WR).
// in_ready is high only while loading; it rises again as soon as the last
// result sits in the output register, so the next batch can load while the
// receiver still holds off. A stalled receiver freezes emission with the
// output register full and its payload held.
// Reset (rst_n low, synchronous) empties the batch and the output register;
// RAM contents are not cleared.
`default_nettype none

module byte_merge_sorter #(
  parameter int MAX_ITEMS = bms_pkg::MAX_ITEMS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire bms_pkg::bms_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output bms_pkg::bms_out_t     out_data
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int PW = CW + 1;
  localparam int DW = bms_pkg::ITEM_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  localparam logic [2:0] ST_LOAD    = 3'd0;
  localparam logic [2:0] ST_SETUP   = 3'd1;
  localparam logic [2:0] ST_MERGE   = 3'd2;
  localparam logic [2:0] ST_EMIT_RD = 3'd3;
  localparam logic [2:0] ST_EMIT_WR = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic              sel_r, sel_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              drop_r, drop_nxt;
  logic [CW-1:0]     w_r, w_nxt;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     mid_r, mid_nxt;
  logic [CW-1:0]     hi_r, hi_nxt;
  logic [CW-1:0]     a_r, a_nxt;
  logic [CW-1:0]     b_r, b_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [CW-1:0]     e_r, e_nxt;
  logic              out_valid_r, out_valid_nxt;
  bms_pkg::bms_out_t out_r, out_nxt;

  logic              we0, we1;
  logic [AW-1:0]     waddr;
  logic [DW-1:0]     wdata;
  logic              re_a, re_b;
  logic [AW-1:0]     raddr_a, raddr_b;
  logic [DW-1:0]     rd_a0, rd_b0, rd_a1, rd_b1;
  logic [DW-1:0]     rd_a, rd_b;

  logic [PW-1:0]     lo_w, lo_2w, cnt_p;
  logic [CW-1:0]     mid_c, hi_c;
  logic [CW-1:0]     a_inc, b_inc, k_inc, e_inc;
  logic              a_ok, b_ok, take_b;

  bms_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_ram0 (
    .clk     (clk),
    .we      (we0),
    .waddr   (waddr),
    .wdata   (wdata),
    .re_a    (re_a & ~sel_r),
    .raddr_a (raddr_a),
    .re_b    (re_b & ~sel_r),
    .raddr_b (raddr_b),
    .rd_a_r  (rd_a0),
    .rd_b_r  (rd_b0)
  );

  bms_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_ram1 (
    .clk     (clk),
    .we      (we1),
    .waddr   (waddr),
    .wdata   (wdata),
    .re_a    (re_a & sel_r),
    .raddr_a (raddr_a),
    .re_b    (re_b & sel_r),
    .raddr_b (raddr_b),
    .rd_a_r  (rd_a1),
    .rd_b_r  (rd_b1)
  );

  assign rd_a = sel_r ? rd_a1 : rd_a0;
  assign rd_b = sel_r ? rd_b1 : rd_b0;

  // run bounds of the pair starting at lo
  assign cnt_p = {1'b0, cnt_r};
  assign lo_w  = {1'b0, lo_r} + {1'b0, w_r};
  assign lo_2w = {1'b0, lo_r} + {w_r, 1'b0};
  assign mid_c = (lo_w  > cnt_p) ? cnt_r : lo_w[CW-1:0];
  assign hi_c  = (lo_2w > cnt_p) ? cnt_r : lo_2w[CW-1:0];

  assign a_inc = a_r + ONE_C;
  assign b_inc = b_r + ONE_C;
  assign k_inc = k_r + ONE_C;
  assign e_inc = e_r + ONE_C;

  assign a_ok   = a_r < mid_r;
  assign b_ok   = b_r < hi_r;
  // ties go to the left run
  assign take_b = b_ok && (!a_ok || ($signed(rd_b) < $signed(rd_a)));

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    w_nxt         = w_r;
    lo_nxt        = lo_r;
    mid_nxt       = mid_r;
    hi_nxt        = hi_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    k_nxt         = k_r;
    e_nxt         = e_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    we0           = 1'b0;
    we1           = 1'b0;
    waddr         = k_r[AW-1:0];
    wdata         = take_b ? rd_b : rd_a;
    re_a          = 1'b0;
    re_b          = 1'b0;
    raddr_a       = a_inc[AW-1:0];
    raddr_b       = b_inc[AW-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (cnt_r < MAX_C) begin
            we0     = 1'b1;
            waddr   = cnt_r[AW-1:0];
            wdata   = in_data.item;
            cnt_nxt = cnt_r + ONE_C;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_data.last_item) begin
            sel_nxt = 1'b0;
            e_nxt   = '0;
            w_nxt   = ONE_C;
            lo_nxt  = '0;
            if (cnt_nxt == ONE_C) begin
              state_nxt = ST_EMIT_RD;
            end else begin
              state_nxt = ST_SETUP;
            end
          end
        end
      end
      ST_SETUP: begin
        a_nxt     = lo_r;
        b_nxt     = mid_c;
        mid_nxt   = mid_c;
        hi_nxt    = hi_c;
        k_nxt     = lo_r;
        re_a      = 1'b1;
        raddr_a   = lo_r[AW-1:0];
        re_b      = mid_c < hi_c;
        raddr_b   = mid_c[AW-1:0];
        state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        we0   = sel_r;
        we1   = ~sel_r;
        k_nxt = k_inc;
        if (take_b) begin
          b_nxt = b_inc;
          re_b  = b_inc < hi_r;
        end else begin
          a_nxt = a_inc;
          re_a  = a_inc < mid_r;
        end
        if (k_inc == hi_r) begin
          lo_nxt    = hi_r;
          state_nxt = ST_SETUP;
          if (hi_r == cnt_r) begin
            sel_nxt = ~sel_r;
            lo_nxt  = '0;
            if ({w_r, 1'b0} >= cnt_p) begin
              e_nxt     = '0;
              state_nxt = ST_EMIT_RD;
            end else begin
              w_nxt = {w_r[CW-2:0], 1'b0};
            end
          end
        end
      end
      ST_EMIT_RD: begin
        re_a      = 1'b1;
        raddr_a   = e_r[AW-1:0];
        state_nxt = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.sorted_item = rd_a;
          out_nxt.last_result = e_inc == cnt_r;
          out_nxt.overflow    = drop_r;
          out_valid_nxt       = 1'b1;
          e_nxt               = e_inc;
          if (e_inc == cnt_r) begin
            cnt_nxt   = '0;
            drop_nxt  = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      sel_r       <= 1'b0;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r   <= w_nxt;
    lo_r  <= lo_nxt;
    mid_r <= mid_nxt;
    hi_r  <= hi_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    k_r   <= k_nxt;
    e_r   <= e_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### rtl/core/bms_chk.sv
`default_nettype none

module bms_chk (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire bms_pkg::bms_in_t  in_data,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire bms_pkg::bms_out_t out_data
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_item |=> !in_ready)
    else $error("input taken after closing beat");

  a_emit_blocks_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_result |-> !in_ready)
    else $error("input open while batch still emitting");

endmodule

bind byte_merge_sorter bms_chk u_bms_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
